// File: src/nfre_pkg.sv
// Shared types, widths and codes for the neuron firing-rate estimator.
// No dependencies; imported by every module of the block.
`default_nettype none

package nfre_pkg;

  // Sizes
  localparam int LOCAL_NEURONS   = 1024;
  localparam int NIDX_W          = $clog2(LOCAL_NEURONS);
  localparam int RANKS           = 4;
  localparam int RANK_W          = $clog2(RANKS);
  localparam int REMOTE_PER_RANK = 1024;
  localparam int RKEY_W          = RANK_W + $clog2(REMOTE_PER_RANK);
  localparam int FRAC_BITS       = 16;
  localparam int RATE_W          = FRAC_BITS + 1;
  localparam int RND_W           = 16;
  localparam int COUNT_W         = 32;
  localparam int STEP_W          = 32;
  localparam int MODE_W          = 3;
  localparam int QCNT_W          = $clog2(FRAC_BITS + 1);

  // Stream payload widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;

  // 1.0 in Q1.16
  localparam logic [RATE_W-1:0] RATE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Item kinds
  localparam logic [MODE_W-1:0] MODE_FIRED = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SYNC  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STORE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;

  // One result beat; rate sits in the low bits when packed
  typedef struct packed {
    logic              error;
    logic              active;
    logic              found;
    logic [RATE_W-1:0] rate;
  } res_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic latch;      // capture the input beat
    logic sweep;      // counter, rate and valid-row memories addressed by the sweep index
    logic sweep_rst;  // sweep index back to zero
    logic sweep_inc;  // advance sweep index
    logic clr_mem;    // post-reset clear of row at sweep index
    logic sync_wr;    // write rate, zero counter, drop remote row
    logic vrow_clr;   // drop remote valid row only
    logic exec_wr;    // per-item memory update
    logic res_cap;    // hold the result of the current item
    logic sync_begin; // record step and elapsed count
    logic div_start;  // start one division
    logic load_now;   // output register from the live result
    logic load_held;  // output register from the held result
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              step_lt;
    logic              step_eq;
    logic              sweep_last;
    logic              div_done;
    logic              out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: src/nfre_div.sv
// Radix-2 restoring divider: count * 2^16 / elapsed, saturated at 1.0.
// Depends on nfre_pkg. One quotient bit per cycle.
`default_nettype none

module nfre_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [nfre_pkg::COUNT_W-1:0]  dividend,
  input  wire logic [nfre_pkg::STEP_W-1:0]   divisor,
  output logic                               done,
  output logic [nfre_pkg::RATE_W-1:0]        quotient
);
  import nfre_pkg::*;

  logic                 busy;
  logic [QCNT_W-1:0]    cnt;
  logic [COUNT_W-1:0]   rem;
  logic [FRAC_BITS-1:0] quo;
  logic                 sat;

  logic [COUNT_W:0] shifted;
  logic [COUNT_W:0] diff;
  logic             ge;

  // Trial subtract of the shifted remainder
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= QCNT_W'(FRAC_BITS);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      quo <= '0;
      sat <= dividend >= divisor;
    end else if (busy && cnt != '0) begin
      rem <= ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo <= {quo[FRAC_BITS-2:0], ge};
    end
  end

  assign done     = busy && (cnt == '0);
  assign quotient = sat ? RATE_ONE : {1'b0, quo};

endmodule

`default_nettype wire

// File: src/nfre_dp.sv
// Datapath: item registers, counter / rate / remote memories, divider, output register.
// Depends on nfre_pkg and nfre_div.
`default_nettype none

module nfre_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire nfre_pkg::dp_cmd_t                cmd,
  output nfre_pkg::dp_sts_t                     sts,
  input  wire logic [nfre_pkg::IN_DATA_W-1:0]   in_data,
  input  wire logic [nfre_pkg::MODE_W-1:0]      in_mode,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [nfre_pkg::OUT_DATA_W-1:0]       out_data
);
  import nfre_pkg::*;

  // Input field offsets in tdata
  localparam int IDX_LO   = 0;
  localparam int FIRED_LO = IDX_LO + NIDX_W;
  localparam int STEP_LO  = FIRED_LO + 1;
  localparam int RANK_LO  = STEP_LO + STEP_W;
  localparam int RIN_LO   = RANK_LO + RANK_W;
  localparam int RND_LO   = RIN_LO + RATE_W;
  localparam int RES_W    = RATE_W + 3;

  // Memories
  logic [COUNT_W-1:0] counts [LOCAL_NEURONS];
  logic [RATE_W-1:0]  lrates [LOCAL_NEURONS];
  logic [RATE_W-1:0]  rrates [RANKS*REMOTE_PER_RANK];
  logic [RANKS-1:0]   vrows  [LOCAL_NEURONS];

  // Item registers
  logic [MODE_W-1:0]  mode;
  logic [NIDX_W-1:0]  idx;
  logic               fired;
  logic [STEP_W-1:0]  step;
  logic [RANK_W-1:0]  rank;
  logic [RATE_W-1:0]  rate_in;
  logic [RND_W-1:0]   rnd;

  logic [STEP_W-1:0]  last_step;
  logic [STEP_W-1:0]  elapsed;
  logic [NIDX_W-1:0]  sweep_i;

  // Registered read data
  logic [COUNT_W-1:0] count_q;
  logic [RATE_W-1:0]  lrate_q;
  logic [RATE_W-1:0]  rrate_q;
  logic [RANKS-1:0]   vrow_q;

  logic [NIDX_W-1:0]  in_idx;
  logic [RANK_W-1:0]  in_rank;
  logic [NIDX_W-1:0]  rd_addr;
  logic [NIDX_W-1:0]  wr_addr;
  logic [RKEY_W-1:0]  rkey_rd;
  logic [RKEY_W-1:0]  rkey_wr;

  logic               div_done;
  logic [RATE_W-1:0]  div_rate;

  res_t               res;
  res_t               res_held;
  logic               found;
  logic [RATE_W-1:0]  rate_sat;

  logic               cnt_we;
  logic [COUNT_W-1:0] cnt_wd;
  logic               lr_we;
  logic [RATE_W-1:0]  lr_wd;
  logic               vr_we;
  logic [RANKS-1:0]   vr_wd;
  logic               rr_we;
  logic               is_store;

  assign in_idx  = in_data[IDX_LO +: NIDX_W];
  assign in_rank = in_data[RANK_LO +: RANK_W];

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode    <= in_mode;
      idx     <= in_idx;
      fired   <= in_data[FIRED_LO];
      step    <= in_data[STEP_LO +: STEP_W];
      rank    <= in_rank;
      rate_in <= in_data[RIN_LO +: RATE_W];
      rnd     <= in_data[RND_LO +: RND_W];
    end
  end

  // Last sync step and elapsed steps
  always_ff @(posedge clk) begin
    if (rst) begin
      last_step <= '0;
    end else if (cmd.sync_begin) begin
      last_step <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sync_begin) begin
      elapsed <= step - last_step;
    end
  end

  // Sweep index
  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_rst) begin
      sweep_i <= '0;
    end else if (cmd.sweep_inc) begin
      sweep_i <= sweep_i + 1'b1;
    end
  end

  // Addresses
  assign rd_addr = cmd.sweep ? sweep_i : in_idx;
  assign wr_addr = cmd.sweep ? sweep_i : idx;
  assign rkey_rd = {in_rank, in_idx};
  assign rkey_wr = {rank, idx};

  // Write decode
  assign is_store = cmd.exec_wr && (mode == MODE_STORE);
  assign cnt_we   = cmd.clr_mem || cmd.sync_wr ||
                    (cmd.exec_wr && mode == MODE_FIRED && fired && count_q != '1);
  assign cnt_wd   = cmd.exec_wr ? count_q + 1'b1 : '0;
  assign lr_we    = cmd.clr_mem || cmd.sync_wr;
  assign lr_wd    = cmd.clr_mem ? '0 : div_rate;
  assign vr_we    = cmd.clr_mem || cmd.sync_wr || cmd.vrow_clr || is_store;
  assign vr_wd    = is_store ? (vrow_q | (RANKS'(1) << rank)) : '0;
  assign rr_we    = is_store;
  assign rate_sat = (rate_in > RATE_ONE) ? RATE_ONE : rate_in;

  // Spike counters
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      counts[wr_addr] <= cnt_wd;
    end
    count_q <= counts[rd_addr];
  end

  // Local rates
  always_ff @(posedge clk) begin
    if (lr_we) begin
      lrates[wr_addr] <= lr_wd;
    end
    lrate_q <= lrates[rd_addr];
  end

  // Remote valid rows, one bit per rank
  always_ff @(posedge clk) begin
    if (vr_we) begin
      vrows[wr_addr] <= vr_wd;
    end
    vrow_q <= vrows[rd_addr];
  end

  // Remote rate cache
  always_ff @(posedge clk) begin
    if (rr_we) begin
      rrates[rkey_wr] <= rate_sat;
    end
    rrate_q <= rrates[rkey_rd];
  end

  nfre_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (count_q),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (div_rate)
  );

  // Result of the current item
  assign found = vrow_q[rank];
  always_comb begin
    res = '0;
    case (mode)
      MODE_READ: begin
        res.rate = lrate_q;
      end
      MODE_QUERY: begin
        res.found  = found;
        res.rate   = found ? rrate_q : '0;
        res.active = found && (rrate_q >= {1'b0, rnd});
      end
      MODE_SYNC: begin
        res.error = step < last_step;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_cap) begin
      res_held <= res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_now || cmd.load_held) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_now) begin
      out_data <= {(OUT_DATA_W - RES_W)'(0), res};
    end else if (cmd.load_held) begin
      out_data <= {(OUT_DATA_W - RES_W)'(0), res_held};
    end
  end

  // Status
  assign sts.mode       = mode;
  assign sts.step_lt    = step < last_step;
  assign sts.step_eq    = step == last_step;
  assign sts.sweep_last = &sweep_i;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: src/nfre_ctrl.sv
// Controller state machine: item sequencing, sync sweep and post-reset clear.
// Depends on nfre_pkg; drives nfre_dp through dp_cmd_t.
`default_nettype none

module nfre_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire nfre_pkg::dp_sts_t sts,
  output nfre_pkg::dp_cmd_t      cmd
);
  import nfre_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_SRD    = 3'd3;
  localparam logic [2:0] ST_SSTART = 3'd4;
  localparam logic [2:0] ST_SDIV   = 3'd5;
  localparam logic [2:0] ST_VCLR   = 3'd6;
  localparam logic [2:0] ST_RESP   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.sweep     = 1'b1;
        cmd.clr_mem   = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // read address follows the incoming beat
        cmd.latch = accept;
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec_wr = 1'b1;
        cmd.res_cap = 1'b1;
        if (sts.mode == MODE_SYNC && !sts.step_lt) begin
          cmd.sync_begin = 1'b1;
          cmd.sweep_rst  = 1'b1;
          state_next     = sts.step_eq ? ST_VCLR : ST_SRD;
        end else if (sts.out_free) begin
          cmd.load_now = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_SRD: begin
        cmd.sweep  = 1'b1;
        state_next = ST_SSTART;
      end
      ST_SSTART: begin
        cmd.sweep     = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = ST_SDIV;
      end
      ST_SDIV: begin
        cmd.sweep = 1'b1;
        if (sts.div_done) begin
          cmd.sync_wr   = 1'b1;
          cmd.sweep_inc = 1'b1;
          state_next    = sts.sweep_last ? ST_RESP : ST_SRD;
        end
      end
      ST_VCLR: begin
        cmd.sweep     = 1'b1;
        cmd.vrow_clr  = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_held = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

`ifndef SYNTH
  // reset always restarts the clearing pass
  a_rst_clear: assert property (@(posedge clk) rst |=> state == ST_CLEAR)
    else $error("reset did not enter clearing pass");

  // an accepted beat is worked on in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted beat not executed");

  // divider completes only while the sweep waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == ST_SDIV)
    else $error("divider done outside sweep");

  // output register never overwritten while a beat is pending
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_now || cmd.load_held) |-> sts.out_free)
    else $error("result loaded over pending beat");
`endif

endmodule

`default_nettype wire

// File: src/neuron_firing_rate_estimator_unit.sv
// Fired, read, store, query and out-of-order sync beats: one memory read on accept, then
// write/result in ST_EXEC; the next beat is accepted only after the result is loaded,
// which waits in ST_RESP while the output is stalled. Sync: the sweep runs each neuron
// through the radix-2 divider; a sync at the last sync step only clears the remote valid
// rows. Synchronous reset, then a clearing pass of the counter, rate and remote valid
// memories before the first beat is accepted.
`default_nettype none

module neuron_firing_rate_estimator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // neuron_index, fired, step_number, source_rank, rate_in, random_fraction, zero pad
  input  wire logic [nfre_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // mode
  input  wire logic [nfre_pkg::MODE_W-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // rate_out, found, active, error, zero pad
  output logic [nfre_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import nfre_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  nfre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nfre_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .in_mode   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: tb/neuron_firing_rate_estimator_unit_test.sv
// Self-checking bench for neuron_firing_rate_estimator_unit: directed table, then random traffic.
// Needs only nfre_pkg and the unit; each result beat is checked against the table or a local predictor.

module neuron_firing_rate_estimator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nfre_pkg::*;

  // Modes the block must ignore
  localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  localparam int RANDOM_BEATS   = 1425;
  localparam int MAX_RAND_SYNCS = 32;
  localparam int DRAIN_CYCLES   = 64;
  localparam int CYCLE_LIMIT    = 4_000_000;
  localparam int N_PLAN         = 27;

  // One input beat: mode, then the tdata fields in tdata order
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NIDX_W-1:0] idx;
    logic              fired;
    logic [STEP_W-1:0] step;
    logic [RANK_W-1:0] rank;
    logic [RATE_W-1:0] rate_in;
    logic [RND_W-1:0]  rnd;
  } beat_in_t;

  typedef struct packed {
    beat_in_t beat;
    logic     typed;  // 1: use the typed-in result below
    res_t     want;
  } plan_row_t;

  localparam res_t RES_NONE = '0;
  localparam res_t RES_ERR  = '{error: 1'b1, active: 1'b0, found: 1'b0, rate: '0};
  localparam res_t RES_FULL = '{error: 1'b0, active: 1'b0, found: 1'b0, rate: RATE_ONE};
  localparam res_t RES_HIT_FULL = '{error: 1'b0, active: 1'b1, found: 1'b1, rate: RATE_ONE};

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  neuron_firing_rate_estimator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor state
  logic [COUNT_W-1:0] spike_tally [LOCAL_NEURONS];
  logic [RATE_W-1:0]  local_rate [LOCAL_NEURONS];
  logic [RATE_W-1:0]  remote_rate [RANKS*REMOTE_PER_RANK];
  logic               remote_held [RANKS*REMOTE_PER_RANK];
  logic [STEP_W-1:0]  last_sync;
  logic [RKEY_W-1:0]  cached_keys [$];

  res_t      pending_results [$];
  plan_row_t plan [N_PLAN];

  int  fail_count;
  int  cycle_count;
  int  results_checked;
  int  sync_count;
  int  sync_rejects;
  int  cache_hits;
  int  sink_wait;
  bit  steady;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic beat_in_t mk_beat(logic [MODE_W-1:0] mode, int idx, bit fired,
                                       logic [STEP_W-1:0] step, int rank, int rate_in,
                                       int rnd);
    beat_in_t b;
    b.mode    = mode;
    b.idx     = idx[NIDX_W-1:0];
    b.fired   = fired;
    b.step    = step;
    b.rank    = rank[RANK_W-1:0];
    b.rate_in = rate_in[RATE_W-1:0];
    b.rnd     = rnd[RND_W-1:0];
    return b;
  endfunction

  function automatic plan_row_t row(beat_in_t b, bit typed, res_t want);
    plan_row_t r;
    r.beat  = b;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Q1.16 rate from a spike count over the elapsed steps, truncated, saturated at 1.0
  function automatic logic [RATE_W-1:0] q16_rate(logic [COUNT_W-1:0] count,
                                                 logic [STEP_W-1:0] elapsed);
    logic [63:0] quot;
    if (count >= elapsed) return RATE_ONE;
    quot = ({32'b0, count} << FRAC_BITS) / {32'b0, elapsed};
    return quot[RATE_W-1:0];
  endfunction

  // Advances the predictor by one beat and returns the result it must produce
  function automatic res_t estimate_result(beat_in_t b);
    res_t              res;
    logic [RKEY_W-1:0] key;
    logic [STEP_W-1:0] elapsed;
    res = '0;
    key = {b.rank, b.idx};
    case (b.mode)
      MODE_FIRED: begin
        if (b.fired && spike_tally[b.idx] != '1) spike_tally[b.idx] += 1;
      end
      MODE_SYNC: begin
        sync_count++;
        if (b.step < last_sync) begin
          res.error = 1'b1;
          sync_rejects++;
        end else begin
          if (b.step != last_sync) begin
            elapsed = b.step - last_sync;
            for (int n = 0; n < LOCAL_NEURONS; n++) begin
              local_rate[n]  = q16_rate(spike_tally[n], elapsed);
              spike_tally[n] = '0;
            end
          end
          foreach (remote_held[k]) remote_held[k] = 1'b0;
          cached_keys.delete();
          last_sync = b.step;
        end
      end
      MODE_READ: res.rate = local_rate[b.idx];
      MODE_STORE: begin
        remote_rate[key] = (b.rate_in > RATE_ONE) ? RATE_ONE : b.rate_in;
        remote_held[key] = 1'b1;
        cached_keys.push_back(key);
      end
      MODE_QUERY: begin
        if (remote_held[key]) begin
          res.found  = 1'b1;
          res.rate   = remote_rate[key];
          res.active = (remote_rate[key] >= {1'b0, b.rnd});
          cache_hits++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Present one beat after a random gap (none while steady), wait for the handshake, then log the expectation
  task automatic send_beat(beat_in_t b, bit typed, res_t want);
    int   gap;
    res_t predicted;
    gap = steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.mode;
    s_axis_tdata  <= {2'b00, b.rnd, b.rate_in, b.rank, b.step, b.fired, b.idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = estimate_result(b);
    pending_results.push_back(typed ? want : predicted);
    if ($urandom_range(0, 99) == 0) steady = !steady;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: stall at random (not while steady), check each accepted beat against the oldest expectation
  initial begin
    forever begin
      @(negedge clk);
      if (sink_wait > 0 && !steady) begin
        m_axis_tready <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation pending: rate=%0d found=%0b active=%0b error=%0b",
               got.rate, got.found, got.active, got.error);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("rate_out", want.rate, got.rate);
        check_field("found", want.found, got.found);
        check_field("active", want.active, got.active);
        check_field("error", want.error, got.error);
      end
      results_checked++;
      sink_wait = $urandom_range(0, 5);
    end
  end

  // Stimulus
  initial begin
    beat_in_t          b;
    int                pick;
    int                rand_syncs;
    logic [RKEY_W-1:0] key;
    logic [RATE_W-1:0] held;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    fail_count    = 0;
    cycle_count   = 0;
    results_checked = 0;
    sync_count    = 0;
    sync_rejects  = 0;
    cache_hits    = 0;
    sink_wait     = 0;
    steady        = 1'b0;
    rand_syncs    = 0;
    last_sync     = '0;
    foreach (spike_tally[n]) begin
      spike_tally[n] = '0;
      local_rate[n]  = '0;
    end
    foreach (remote_held[k]) begin
      remote_held[k] = 1'b0;
      remote_rate[k] = '0;
    end

    plan = '{
      row(mk_beat(MODE_READ,  0,    0, 0,  0, 0, 0), 1, RES_NONE),       // fresh rate is zero
      row(mk_beat(MODE_QUERY, 0,    0, 0,  0, 0, 0), 1, RES_NONE),       // empty cache
      row(mk_beat(MODE_FIRED, 5,    1, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_FIRED, 5,    1, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_FIRED, 5,    1, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_FIRED, 5,    0, 0,  0, 0, 0), 1, RES_NONE),       // not fired: no count
      row(mk_beat(MODE_FIRED, 1023, 1, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_SYNC,  0,    0, 0,  0, 0, 0), 1, RES_NONE),       // same step: counts kept
      row(mk_beat(MODE_SYNC,  0,    0, 4,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_READ,  5,    0, 0,  0, 0, 0), 0, RES_NONE),
      row(mk_beat(MODE_READ,  1023, 0, 0,  0, 0, 0), 0, RES_NONE),
      row(mk_beat(MODE_FIRED, 7,    1, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_FIRED, 7,    1, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_SYNC,  0,    0, 6,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_READ,  7,    0, 0,  0, 0, 0), 1, RES_FULL),       // count == elapsed
      row(mk_beat(MODE_SYNC,  0,    0, 3,  0, 0, 0), 1, RES_ERR),        // step goes backward
      row(mk_beat(MODE_STORE, 1023, 0, 0,  3, 'h1FFFF, 0), 1, RES_NONE), // clipped to 1.0
      row(mk_beat(MODE_QUERY, 1023, 0, 0,  3, 0, 'hFFFF), 1, RES_HIT_FULL),
      row(mk_beat(MODE_STORE, 2,    0, 0,  1, 'h8000, 0), 1, RES_NONE),
      row(mk_beat(MODE_QUERY, 2,    0, 0,  1, 0, 'h8000), 0, RES_NONE),  // equal: active
      row(mk_beat(MODE_QUERY, 2,    0, 0,  1, 0, 'h8001), 0, RES_NONE),  // one above: idle
      row(mk_beat(MODE_SPARE5, 0,   0, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_SPARE6, 0,   0, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_SPARE7, 0,   0, 0,  0, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_SYNC,  0,    0, 6,  0, 0, 0), 1, RES_NONE),       // same step: cache dropped
      row(mk_beat(MODE_QUERY, 1023, 0, 0,  3, 0, 0), 1, RES_NONE),
      row(mk_beat(MODE_SYNC,  0,    0, 32'h8000_0000, 0, 0, 0), 1, RES_NONE)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int i = 0; i < N_PLAN; i++) send_beat(plan[i].beat, plan[i].typed, plan[i].want);

    // Random traffic: bursts of fires on a hot set, reads, stores then queries on cached keys,
    // unused modes, and occasional syncs, mostly small steps, so rates span zero to full
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      b = mk_beat(MODE_FIRED, $urandom_range(0, LOCAL_NEURONS - 1), $urandom_range(0, 1),
                  $urandom(), $urandom_range(0, RANKS - 1), $urandom_range(0, 'h1FFFF),
                  $urandom_range(0, 'hFFFF));
      pick = $urandom_range(0, 99);
      if (pick >= 98 && rand_syncs >= MAX_RAND_SYNCS) pick = 70;
      if (pick < 40) begin
        b.mode = MODE_FIRED;
        if ($urandom_range(0, 3) != 0) b.idx = NIDX_W'($urandom_range(0, 15));
        b.fired = ($urandom_range(0, 99) < 85);
      end else if (pick < 55 || (pick >= 95 && pick < 98)) begin
        b.mode = MODE_READ;
        if ($urandom_range(0, 4) < 3) b.idx = NIDX_W'($urandom_range(0, 15));
      end else if (pick < 70) begin
        b.mode = MODE_STORE;
        case ($urandom_range(0, 7))
          0: b.rate_in = '0;
          1: b.rate_in = RATE_ONE;
          2: b.rate_in = RATE_W'($urandom_range(int'(RATE_ONE) + 1, 'h1FFFF));
          default: b.rate_in = RATE_W'($urandom_range(0, int'(RATE_ONE)));
        endcase
      end else if (pick < 92) begin
        b.mode = MODE_QUERY;
        if (cached_keys.size() != 0 && $urandom_range(0, 9) < 7) begin
          key    = cached_keys[$urandom_range(0, cached_keys.size() - 1)];
          b.rank = key[RKEY_W-1:NIDX_W];
          b.idx  = key[NIDX_W-1:0];
          held   = remote_rate[key];
          case ($urandom_range(0, 3))
            0: b.rnd = held[RND_W-1:0];
            1: b.rnd = held[RND_W-1:0] + 1'b1;
            default: ;
          endcase
        end
      end else if (pick < 95) begin
        case ($urandom_range(0, 2))
          0: b.mode = MODE_SPARE5;
          1: b.mode = MODE_SPARE6;
          default: b.mode = MODE_SPARE7;
        endcase
      end else begin
        b.mode = MODE_SYNC;
        rand_syncs++;
        pick = $urandom_range(0, 9);
        if (pick == 0 && last_sync != 0) b.step = $urandom_range(0, last_sync - 1);
        else if (pick == 1) b.step = last_sync;
        else if (pick == 2) b.step = last_sync + $urandom_range(1, 1 << 20);
        else if (pick < 6) b.step = last_sync + $urandom_range(1, 8);
        else b.step = last_sync + $urandom_range(1, 64);
      end
      send_beat(b, 1'b0, RES_NONE);
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // Drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d beats including %0d syncs (%0d out of order); %0d results checked,",
             N_PLAN + RANDOM_BEATS, sync_count, sync_rejects, results_checked);
    $display("%0d remote queries hit the cache, %0d mismatches.", cache_hits, fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
